// File: design/zsep_pkg.sv
// ----------------------------------------------------------------------------
// zsep_pkg
// Types, result kinds, parse phases and header constants shared by the
// stored-entry archive stream parser.
// ----------------------------------------------------------------------------
package zsep_pkg;

	localparam logic [31:0] SIG_CENTRAL = 32'h0201_4b50;
	localparam logic [31:0] SIG_END     = 32'h0605_4b50;
	localparam logic [31:0] SIG_LOCAL   = 32'h0403_4b50;
	localparam logic [15:0] FLAG_DESCRIPTOR = 16'h0008;
	localparam int HDR_LEN = 26;

	// byte offsets inside the 26-byte local header
	localparam logic [4:0] OFS_FLAGS_LO  = 5'd2;
	localparam logic [4:0] OFS_METHOD_LO = 5'd4;
	localparam logic [4:0] OFS_METHOD_HI = 5'd5;
	localparam logic [4:0] OFS_CSIZE_0   = 5'd14;
	localparam logic [4:0] OFS_CSIZE_1   = 5'd15;
	localparam logic [4:0] OFS_CSIZE_2   = 5'd16;
	localparam logic [4:0] OFS_CSIZE_3   = 5'd17;
	localparam logic [4:0] OFS_USIZE_0   = 5'd18;
	localparam logic [4:0] OFS_USIZE_1   = 5'd19;
	localparam logic [4:0] OFS_USIZE_2   = 5'd20;
	localparam logic [4:0] OFS_USIZE_3   = 5'd21;
	localparam logic [4:0] OFS_NAME_LO   = 5'd22;
	localparam logic [4:0] OFS_NAME_HI   = 5'd23;
	localparam logic [4:0] OFS_EXTRA_LO  = 5'd24;
	localparam logic [4:0] OFS_EXTRA_HI  = 5'd25;

	localparam logic [15:0] MAX_NAME_RST = 16'd255;

	localparam logic [1:0] ERR_SIG    = 2'd0;
	localparam logic [1:0] ERR_COMP   = 2'd1;
	localparam logic [1:0] ERR_DESC   = 2'd2;
	localparam logic [1:0] ERR_NAME   = 2'd3;

	localparam int MAX_RES = 3;

	typedef enum logic [2:0] {
		K_HEADER = 3'd0,
		K_NAME   = 3'd1,
		K_START  = 3'd2,
		K_DATA   = 3'd3,
		K_END    = 3'd4,
		K_DONE   = 3'd5,
		K_ERROR  = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		PH_SIG   = 3'd0,
		PH_HDR   = 3'd1,
		PH_NAME  = 3'd2,
		PH_EXTRA = 3'd3,
		PH_DATA  = 3'd4,
		PH_DONE  = 3'd5,
		PH_ERR   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [31:0] entry_size;
		logic [1:0]  error_code;
		logic        last;
	} result_t;

	// all results caused by one input byte
	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [1:0]            cnt;
	} bundle_t;

	function automatic result_t mk_res(kind_t k, logic [7:0] v, logic [31:0] sz,
			logic [1:0] ec);
		result_t r;
		r.kind       = k;
		r.value      = v;
		r.entry_size = sz;
		r.error_code = ec;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// File: design/zsep_parser.sv
// ----------------------------------------------------------------------------
// zsep_parser
// Input register and header/entry state machine. Turns the registered byte
// into a bundle of up to three results in one pass.
// ----------------------------------------------------------------------------
module zsep_parser import zsep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_name_len,
	input  logic        load_ok,
	output logic        push,
	output bundle_t     bnd
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;

	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [23:0] sig_q, sig_d;
	logic        desc_q, desc_d;
	logic        method_nz_q, method_nz_d;
	logic [31:0] left_q, left_d;
	logic [31:0] usize_q, usize_d;
	logic [15:0] name_len_q, name_len_d;
	logic [15:0] extra_len_q, extra_len_d;
	logic [1:0]  err_q, err_d;

	assign adv      = valid_s1 && load_ok;
	assign in_stall = valid_s1 && !load_ok;
	assign push     = adv && (bnd.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIG;
			count_q     <= '0;
			sig_q       <= '0;
			desc_q      <= 1'b0;
			method_nz_q <= 1'b0;
			left_q      <= '0;
			usize_q     <= '0;
			name_len_q  <= '0;
			extra_len_q <= '0;
			err_q       <= ERR_SIG;
		end else if (adv) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			sig_q       <= sig_d;
			desc_q      <= desc_d;
			method_nz_q <= method_nz_d;
			left_q      <= left_d;
			usize_q     <= usize_d;
			name_len_q  <= name_len_d;
			extra_len_q <= extra_len_d;
			err_q       <= err_d;
		end
	end

	always_comb begin
		logic [1:0]  n;
		logic [7:0]  b;
		logic [16:0] cnt_inc;
		logic [31:0] sig_word;
		logic [31:0] left_dec;

		phase_d     = phase_q;
		count_d     = count_q;
		sig_d       = sig_q;
		desc_d      = desc_q;
		method_nz_d = method_nz_q;
		left_d      = left_q;
		usize_d     = usize_q;
		name_len_d  = name_len_q;
		extra_len_d = extra_len_q;
		err_d       = err_q;
		bnd         = '0;
		n           = 2'd0;
		b           = byte_s1;
		cnt_inc     = {1'b0, count_q} + 17'd1;
		sig_word    = {b, sig_q};
		left_dec    = left_q - 32'd1;

		case (phase_q)
			PH_SIG: begin
				case (count_q[1:0])
					2'd0:    sig_d[7:0]   = b;
					2'd1:    sig_d[15:8]  = b;
					2'd2:    sig_d[23:16] = b;
					default: sig_d        = sig_q;
				endcase
				count_d = cnt_inc[15:0];
				bnd.res[n] = mk_res(K_HEADER, 8'd0, 32'd0, 2'd0);
				n = n + 2'd1;
				if (count_q == 16'd3) begin
					if (sig_word == SIG_CENTRAL || sig_word == SIG_END) begin
						phase_d = PH_DONE;
						bnd.res[n] = mk_res(K_DONE, 8'd0, 32'd0, 2'd0);
						n = n + 2'd1;
					end else if (sig_word != SIG_LOCAL) begin
						phase_d = PH_ERR;
						err_d   = ERR_SIG;
						bnd.res[n] = mk_res(K_ERROR, 8'd0, 32'd0, ERR_SIG);
						n = n + 2'd1;
					end else begin
						phase_d = PH_HDR;
						count_d = '0;
					end
				end
			end
			PH_HDR: begin
				count_d = cnt_inc[15:0];
				bnd.res[n] = mk_res(K_HEADER, 8'd0, 32'd0, 2'd0);
				n = n + 2'd1;
				case (count_q[4:0])
					OFS_FLAGS_LO:  desc_d = |(b & FLAG_DESCRIPTOR[7:0]);
					OFS_METHOD_LO: method_nz_d = (b != 8'd0);
					OFS_METHOD_HI: method_nz_d = method_nz_q || (b != 8'd0);
					OFS_CSIZE_0:   left_d[7:0]   = b;
					OFS_CSIZE_1:   left_d[15:8]  = b;
					OFS_CSIZE_2:   left_d[23:16] = b;
					OFS_CSIZE_3:   left_d[31:24] = b;
					OFS_USIZE_0:   usize_d[7:0]   = b;
					OFS_USIZE_1:   usize_d[15:8]  = b;
					OFS_USIZE_2:   usize_d[23:16] = b;
					OFS_USIZE_3:   usize_d[31:24] = b;
					OFS_NAME_LO:   name_len_d[7:0]  = b;
					OFS_NAME_HI:   name_len_d[15:8] = b;
					OFS_EXTRA_LO:  extra_len_d[7:0] = b;
					OFS_EXTRA_HI:  extra_len_d[15:8] = b;
					default:       desc_d = desc_q;
				endcase
				if (count_q == 16'(HDR_LEN - 1)) begin
					// priority: method, then descriptor flag, then name length
					if (method_nz_q) begin
						phase_d = PH_ERR;
						err_d   = ERR_COMP;
						bnd.res[n] = mk_res(K_ERROR, 8'd0, 32'd0, ERR_COMP);
						n = n + 2'd1;
					end else if (desc_q) begin
						phase_d = PH_ERR;
						err_d   = ERR_DESC;
						bnd.res[n] = mk_res(K_ERROR, 8'd0, 32'd0, ERR_DESC);
						n = n + 2'd1;
					end else if (name_len_q == 16'd0 || name_len_q > max_name_len) begin
						phase_d = PH_ERR;
						err_d   = ERR_NAME;
						bnd.res[n] = mk_res(K_ERROR, 8'd0, 32'd0, ERR_NAME);
						n = n + 2'd1;
					end else begin
						phase_d = PH_NAME;
						count_d = '0;
					end
				end
			end
			PH_NAME: begin
				bnd.res[n] = mk_res(K_NAME, b, 32'd0, 2'd0);
				n = n + 2'd1;
				count_d = cnt_inc[15:0];
				if (cnt_inc >= {1'b0, name_len_q}) begin
					count_d = '0;
					if (extra_len_q == 16'd0) begin
						bnd.res[n] = mk_res(K_START, 8'd0, usize_q, 2'd0);
						n = n + 2'd1;
						phase_d = PH_DATA;
						if (left_q == 32'd0) begin
							bnd.res[n] = mk_res(K_END, 8'd0, 32'd0, 2'd0);
							n = n + 2'd1;
							phase_d = PH_SIG;
						end
					end else begin
						phase_d = PH_EXTRA;
					end
				end
			end
			PH_EXTRA: begin
				bnd.res[n] = mk_res(K_HEADER, 8'd0, 32'd0, 2'd0);
				n = n + 2'd1;
				count_d = cnt_inc[15:0];
				if (cnt_inc >= {1'b0, extra_len_q}) begin
					count_d = '0;
					bnd.res[n] = mk_res(K_START, 8'd0, usize_q, 2'd0);
					n = n + 2'd1;
					phase_d = PH_DATA;
					if (left_q == 32'd0) begin
						bnd.res[n] = mk_res(K_END, 8'd0, 32'd0, 2'd0);
						n = n + 2'd1;
						phase_d = PH_SIG;
					end
				end
			end
			PH_DATA: begin
				bnd.res[n] = mk_res(K_DATA, b, 32'd0, 2'd0);
				n = n + 2'd1;
				if (left_q != 32'd0) begin
					left_d = left_dec;
				end
				if (left_q == 32'd0 || left_dec == 32'd0) begin
					bnd.res[n] = mk_res(K_END, 8'd0, 32'd0, 2'd0);
					n = n + 2'd1;
					phase_d = PH_SIG;
					count_d = '0;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				// sticky error: one error result per byte
				phase_d = PH_ERR;
				bnd.res[n] = mk_res(K_ERROR, 8'd0, 32'd0, err_q);
				n = n + 2'd1;
			end
		endcase

		if (n != 2'd0) begin
			bnd.res[n - 2'd1].last = 1'b1;
		end
		bnd.cnt = n;
	end

`ifndef NO_ASSERTIONS
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != 32'd0)
		else $error("data phase entered with no bytes left");
	a_name_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NAME |-> name_len_q != 16'd0 && count_q < name_len_q)
		else $error("name phase with bad count");
	a_extra_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXTRA |-> extra_len_q != 16'd0 && count_q < extra_len_q)
		else $error("extra phase with bad count");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1))
		else $error("input register changed while stalled");
`endif

endmodule

// File: design/zsep_out_buf.sv
// ----------------------------------------------------------------------------
// zsep_out_buf
// Result register holding one bundle; drains it one result per transfer.
// ----------------------------------------------------------------------------
module zsep_out_buf import zsep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     bnd,
	output logic        load_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic [31:0] entry_size,
	output logic [1:0]  error_code,
	output logic        last
);

	result_t [MAX_RES-1:0] res_q;
	logic [1:0]            cnt_q;
	logic [1:0]            idx_q;
	logic                  valid_q;
	logic                  at_end;
	result_t               cur;

	assign at_end  = (idx_q == cnt_q - 2'd1);
	assign load_ok = !valid_q || (!out_stall && at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (push) begin
			valid_q <= 1'b1;
			cnt_q   <= bnd.cnt;
			idx_q   <= '0;
		end else if (valid_q && !out_stall) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= bnd.res;
		end
	end

	assign cur        = res_q[idx_q];
	assign out_valid  = valid_q;
	assign kind       = cur.kind;
	assign value      = cur.value;
	assign entry_size = cur.entry_size;
	assign error_code = cur.error_code;
	assign last       = cur.last;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> cnt_q != 2'd0 && idx_q < cnt_q)
		else $error("result index outside bundle");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (last == at_end))
		else $error("last flag does not match bundle end");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> load_ok)
		else $error("bundle loaded over pending results");
`endif

endmodule

// File: design/zip_stored_entry_stream_parser.sv
// ----------------------------------------------------------------------------
// zip_stored_entry_stream_parser
// Byte-stream parser for archives of stored entries: checks local headers,
// passes name and data bytes through, marks entry start/end and errors.
// ----------------------------------------------------------------------------
//  channel  signals                                   transfer when
//  input    in_valid, in_stall, data_byte              in_valid & !in_stall
//  output   out_valid, out_stall, kind, value,         out_valid & !out_stall
//           entry_size, error_code, last
//  config   cfg_we, cfg_data (max_name_len)            cfg_we
//
// One input byte per cycle while in_stall is low; its results pass through the input
// register and the result register and leave one per cycle while out_stall is low.
// The input stalls while the single-bundle result register has results yet to send.
// Reset clears the parse state and sets max_name_len to 255.
// Output stall backs up through the result register into the input stage.
// ----------------------------------------------------------------------------
module zip_stored_entry_stream_parser import zsep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic [31:0] entry_size,
	output logic [1:0]  error_code,
	output logic        last
);

	logic [15:0] max_name_len_q;
	logic        load_ok;
	logic        push;
	bundle_t     bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= MAX_NAME_RST;
		end else if (cfg_we) begin
			max_name_len_q <= cfg_data;
		end
	end

	zsep_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.max_name_len (max_name_len_q),
		.load_ok      (load_ok),
		.push         (push),
		.bnd          (bnd)
	);

	zsep_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.bnd        (bnd),
		.load_ok    (load_ok),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.entry_size (entry_size),
		.error_code (error_code),
		.last       (last)
	);

endmodule
